// ===== src/wto_pkg.sv =====
// Types and constants shared by the wavetable oscillator.
// Depends on nothing; every other file but wto_ram imports it.
`default_nettype none

package wto_pkg;

	localparam int NOTE_W   = 7;
	localparam int STEP_W   = 9;
	localparam int FRAC_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int OCT_W    = 4;
	localparam int POS_W    = 9;

	localparam logic [FRAC_W-1:0] FRAC_FULL = 16'hFFFF;

	localparam int OUTQ_DEPTH = 4;
	localparam int OQ_AW      = 2;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_NOTE  = 2'd1,
		MODE_WAVE  = 2'd2,
		MODE_TABLE = 2'd3
	} wto_mode_t;

	typedef enum logic [2:0] {
		WF_SQUARE   = 3'd0,
		WF_SINE     = 3'd1,
		WF_TRIANGLE = 3'd2,
		WF_RSAW     = 3'd3,
		WF_LSAW     = 3'd4
	} wto_wave_t;

	typedef enum logic [1:0] {
		KIND_SINE     = 2'd0,
		KIND_SQUARE   = 2'd1,
		KIND_TRIANGLE = 2'd2,
		KIND_SAW      = 2'd3
	} wto_kind_t;

	typedef struct packed {
		wto_mode_t                   mode;
		logic [NOTE_W-1:0]           note_number;
		logic [STEP_W-1:0]           step_whole;
		logic [FRAC_W-1:0]           step_fraction;
		logic [2:0]                  waveform_code;
		wto_kind_t                   table_kind;
		logic [2:0]                  table_octave;
		logic [POS_W-1:0]            table_position;
		logic signed [SAMPLE_W-1:0]  table_value;
	} wto_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       playing;
	} wto_result_t;

	typedef struct packed {
		logic              valid;
		logic              play;
		logic              neg;
		logic [FRAC_W-1:0] frac;
	} wto_meta_t;

endpackage

`default_nettype wire

// ===== src/wto_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module wto_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 12800,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/wto_ctrl.sv =====
// Oscillator state, request handling, phase update and wave memory addressing.
// Depends on wto_pkg.
`default_nettype none

module wto_ctrl import wto_pkg::*; #(
	parameter int SAMPLES_PER_CYCLE = 512,
	parameter int TABLE_OCTAVES = 8,
	localparam int AW = $clog2(SAMPLES_PER_CYCLE * (1 + 3 * TABLE_OCTAVES))
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  wto_item_t           item,
	output logic                busy,
	output logic                we,
	output logic [AW-1:0]       waddr,
	output logic [SAMPLE_W-1:0] wdata,
	output logic [AW-1:0]       raddr,
	output wto_meta_t           meta_s2
);

	localparam int PW = $clog2(SAMPLES_PER_CYCLE);
	localparam int RW = $clog2(1 + 3 * TABLE_OCTAVES);
	localparam int CW = ($clog2(SAMPLES_PER_CYCLE + 1) > STEP_W) ?
		$clog2(SAMPLES_PER_CYCLE + 1) : STEP_W;
	localparam int MOD_STEPS = (SAMPLES_PER_CYCLE >= (1 << STEP_W)) ? 0 :
		$clog2((((1 << STEP_W) - 1) / SAMPLES_PER_CYCLE) + 1);

	function automatic logic [OCT_W-1:0] octave_of(input logic [NOTE_W-1:0] n);
		logic [12:0] p;
		p = 13'(n) * 13'd43;
		return p[12:9];
	endfunction

	logic                 running_q;
	logic [OCT_W-1:0]     cur_oct_q;
	logic [PW-1:0]        cur_swm_q;
	logic                 cur_big_q;
	logic [FRAC_W-1:0]    cur_sf_q;
	wto_wave_t            cur_wf_q;
	logic                 pend_note_q;
	logic [OCT_W-1:0]     pend_oct_q;
	logic [PW-1:0]        pend_swm_q;
	logic                 pend_big_q;
	logic [FRAC_W-1:0]    pend_sf_q;
	logic                 pend_wave_q;
	wto_wave_t            pend_wf_q;
	logic [PW-1:0]        ph_whole_q;
	logic [FRAC_W-1:0]    ph_frac_q;
	logic                 s1_valid_q;
	logic                 s1_play_q;
	logic [AW-1:0]        addr1_s2;

	logic                 is_tick;
	logic                 is_note;
	logic                 is_wave;
	logic                 is_table;
	logic [STEP_W-1:0]    req_rem;
	logic                 req_big;
	logic [FRAC_W:0]      fs;
	logic [PW:0]          ws;
	logic                 ws_ge;
	logic [PW-1:0]        ws_red;
	logic                 start;
	logic                 latch_note;
	logic                 latch_wave;
	logic                 sine;
	logic [RW-1:0]        row_r;
	logic [RW-1:0]        row_w;
	logic                 neg;
	logic [AW-1:0]        base;
	logic [AW-1:0]        addr0;
	logic [AW-1:0]        addr1;
	logic [PW-1:0]        nxt;
	logic                 pos_ok;
	logic                 oct_ok;

	assign is_tick  = accept && (item.mode == MODE_TICK);
	assign is_note  = accept && (item.mode == MODE_NOTE);
	assign is_wave  = accept && (item.mode == MODE_WAVE);
	assign is_table = accept && (item.mode == MODE_TABLE);

	// reduce the whole step below one cycle; remember whether it was oversized
	always_comb begin
		req_rem = item.step_whole;
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (req_rem >= STEP_W'(SAMPLES_PER_CYCLE << k)) begin
				req_rem = req_rem - STEP_W'(SAMPLES_PER_CYCLE << k);
			end
		end
	end

	assign req_big = CW'(item.step_whole) >= CW'(SAMPLES_PER_CYCLE);

	assign fs     = {1'b0, ph_frac_q} + {1'b0, cur_sf_q};
	assign ws     = (PW+1)'(ph_whole_q) + (PW+1)'(cur_swm_q) + (PW+1)'(fs[FRAC_W]);
	assign ws_ge  = ws >= (PW+1)'(SAMPLES_PER_CYCLE);
	assign ws_red = ws_ge ? PW'(ws - (PW+1)'(SAMPLES_PER_CYCLE)) : PW'(ws);

	assign start      = !running_q && pend_note_q && pend_wave_q;
	assign latch_note = is_tick && pend_note_q && (start || (running_q && (cur_big_q || ws_ge)));
	assign latch_wave = is_tick && pend_wave_q && (start || (running_q && (cur_big_q || ws_ge)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			cur_oct_q   <= '0;
			cur_swm_q   <= '0;
			cur_big_q   <= 1'b0;
			cur_sf_q    <= '0;
			cur_wf_q    <= WF_SQUARE;
			pend_note_q <= 1'b0;
			pend_oct_q  <= '0;
			pend_swm_q  <= '0;
			pend_big_q  <= 1'b0;
			pend_sf_q   <= '0;
			pend_wave_q <= 1'b0;
			pend_wf_q   <= WF_SQUARE;
			ph_whole_q  <= '0;
			ph_frac_q   <= '0;
			s1_valid_q  <= 1'b0;
			s1_play_q   <= 1'b0;
			meta_s2     <= '0;
		end else begin
			if (is_note) begin
				pend_note_q <= 1'b1;
				pend_oct_q  <= octave_of(item.note_number);
				pend_swm_q  <= PW'(req_rem);
				pend_big_q  <= req_big;
				pend_sf_q   <= item.step_fraction;
			end else if (latch_note) begin
				pend_note_q <= 1'b0;
			end
			if (is_wave && (item.waveform_code <= 3'(WF_LSAW))) begin
				pend_wave_q <= 1'b1;
				pend_wf_q   <= wto_wave_t'(item.waveform_code);
			end else if (latch_wave) begin
				pend_wave_q <= 1'b0;
			end
			if (latch_note) begin
				cur_oct_q <= pend_oct_q;
				cur_swm_q <= pend_swm_q;
				cur_big_q <= pend_big_q;
				cur_sf_q  <= pend_sf_q;
			end
			if (latch_wave) begin
				cur_wf_q <= pend_wf_q;
			end
			if (is_tick) begin
				if (running_q) begin
					ph_whole_q <= ws_red;
					ph_frac_q  <= fs[FRAC_W-1:0];
				end else if (start) begin
					ph_whole_q <= '0;
					ph_frac_q  <= '0;
					running_q  <= 1'b1;
				end
			end
			s1_valid_q    <= is_tick;
			s1_play_q     <= running_q || start;
			meta_s2.valid <= s1_valid_q;
			meta_s2.play  <= s1_play_q;
			meta_s2.neg   <= neg;
			meta_s2.frac  <= ph_frac_q;
		end
	end

	// table selection for the note now playing
	assign sine = (cur_oct_q >= OCT_W'(TABLE_OCTAVES)) || (cur_wf_q == WF_SINE);
	assign neg  = (cur_oct_q < OCT_W'(TABLE_OCTAVES)) && (cur_wf_q == WF_RSAW);

	always_comb begin
		if (sine) begin
			row_r = '0;
		end else begin
			unique case (cur_wf_q) inside
				WF_SQUARE:        row_r = RW'(1) + RW'(cur_oct_q);
				WF_TRIANGLE:      row_r = RW'(1 + TABLE_OCTAVES) + RW'(cur_oct_q);
				WF_RSAW, WF_LSAW: row_r = RW'(1 + 2 * TABLE_OCTAVES) + RW'(cur_oct_q);
				default:          row_r = '0;
			endcase
		end
	end

	assign nxt   = (ph_whole_q == PW'(SAMPLES_PER_CYCLE - 1)) ? '0 : ph_whole_q + PW'(1);
	assign base  = AW'(row_r) * AW'(SAMPLES_PER_CYCLE);
	assign addr0 = base + AW'(ph_whole_q);
	assign addr1 = base + AW'(nxt);

	always_ff @(posedge clk) begin
		addr1_s2 <= addr1;
	end

	assign raddr = s1_valid_q ? addr0 : addr1_s2;
	assign busy  = s1_valid_q;

	// table word writes
	always_comb begin
		unique case (item.table_kind)
			KIND_SINE:     row_w = '0;
			KIND_SQUARE:   row_w = RW'(1) + RW'(item.table_octave);
			KIND_TRIANGLE: row_w = RW'(1 + TABLE_OCTAVES) + RW'(item.table_octave);
			KIND_SAW:      row_w = RW'(1 + 2 * TABLE_OCTAVES) + RW'(item.table_octave);
			default:       row_w = '0;
		endcase
	end

	assign pos_ok = CW'(item.table_position) < CW'(SAMPLES_PER_CYCLE);
	assign oct_ok = (item.table_kind == KIND_SINE) ||
		(OCT_W'(item.table_octave) < OCT_W'(TABLE_OCTAVES));

	assign we    = is_table && pos_ok && oct_ok;
	assign waddr = AW'(row_w) * AW'(SAMPLES_PER_CYCLE) + AW'(item.table_position);
	assign wdata = item.table_value;

endmodule

`default_nettype wire

// ===== src/wto_interp.sv =====
// Linear interpolation between two adjacent table words on one shared multiplier.
// Depends on wto_pkg.
`default_nettype none

module wto_interp import wto_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  wto_meta_t           meta_s2,
	input  logic [SAMPLE_W-1:0] rdata,
	output logic                push,
	output wto_result_t         result
);

	localparam int PROD_W = SAMPLE_W + FRAC_W;

	// divide by the full-scale fraction, truncating
	function automatic logic [SAMPLE_W-1:0] quot_full(input logic [PROD_W-1:0] p);
		logic [SAMPLE_W-1:0] q0;
		logic [FRAC_W:0]     r0;
		q0 = p[PROD_W-1:FRAC_W];
		r0 = {1'b0, p[FRAC_W-1:0]} + (FRAC_W+1)'(q0);
		return q0 + SAMPLE_W'(r0 >= {1'b0, FRAC_FULL});
	endfunction

	wto_meta_t           meta_s3;
	wto_meta_t           meta_s4;
	logic                sign_a_s3;
	logic                sign_b_s4;
	logic [SAMPLE_W-1:0] term_a_s4;
	logic [PROD_W-1:0]   prod_q;

	logic [SAMPLE_W-1:0] mag;
	logic [FRAC_W-1:0]   weight;
	logic [SAMPLE_W-1:0] q;
	logic [SAMPLE_W-1:0] term_a;
	logic [SAMPLE_W-1:0] term_b;
	logic [SAMPLE_W-1:0] sum;
	logic [SAMPLE_W-1:0] value;

	assign mag    = rdata[SAMPLE_W-1] ? SAMPLE_W'(0) - rdata : rdata;
	assign weight = meta_s3.valid ? meta_s3.frac : ~meta_s2.frac;
	assign q      = quot_full(prod_q);
	assign term_a = sign_a_s3 ? SAMPLE_W'(0) - q : q;
	assign term_b = sign_b_s4 ? SAMPLE_W'(0) - q : q;
	assign sum    = term_a_s4 + term_b;
	assign value  = meta_s4.neg ? SAMPLE_W'(0) - sum : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s3 <= '0;
			meta_s4 <= '0;
		end else begin
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_q    <= PROD_W'(mag) * PROD_W'(weight);
		sign_a_s3 <= rdata[SAMPLE_W-1];
		sign_b_s4 <= rdata[SAMPLE_W-1];
		term_a_s4 <= term_a;
	end

	assign push              = meta_s4.valid;
	assign result.sample_out = meta_s4.play ? value : '0;
	assign result.playing    = meta_s4.play;

endmodule

`default_nettype wire

// ===== src/wto_outq.sv =====
// Result queue with credit count for ticks in flight.
// Depends on wto_pkg.
`default_nettype none

module wto_outq import wto_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        reserve,
	input  logic        push,
	input  wto_result_t push_data,
	output logic        room,
	output logic        valid,
	input  logic        ready,
	output wto_result_t data
);

	wto_result_t       slot_q [OUTQ_DEPTH];
	logic [OQ_AW-1:0]  wr_ptr_q;
	logic [OQ_AW-1:0]  rd_ptr_q;
	logic [OQ_AW:0]    count_q;
	logic [OQ_AW:0]    credit_q;
	logic              pop;

	assign valid = count_q != '0;
	assign pop   = valid && ready;
	assign room  = credit_q != (OQ_AW+1)'(OUTQ_DEPTH);
	assign data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (OQ_AW+1)'(1);
				2'b01:   count_q <= count_q - (OQ_AW+1)'(1);
				default: count_q <= count_q;
			endcase
			case ({reserve, pop})
				2'b10:   credit_q <= credit_q + (OQ_AW+1)'(1);
				2'b01:   credit_q <= credit_q - (OQ_AW+1)'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/wavetable_oscillator_top.sv =====
// Wavetable oscillator top level: control, wave memory, interpolator, result queue.
// Depends on wto_pkg, wto_ram, wto_ctrl, wto_interp, wto_outq.
//
// beat   handshake             payload        carries
// in     in_valid/in_ready     wto_item_t     tick, note, waveform or table word
// out    out_valid/out_ready   wto_result_t   one sample for each tick
//
// A tick holds off the next beat while both table words come through the one
// read port of the wave memory, one a cycle; note, waveform and table beats do not.
// A tick's result goes through s1, s2, s3, s4 and the result queue. Reset clears
// control state only; there is no clearing pass and wave memory is undefined until
// written. Up to four ticks may be outstanding, and input holds off while four are.
`default_nettype none

module wavetable_oscillator_top import wto_pkg::*; #(
	parameter int SAMPLES_PER_CYCLE = 512,
	parameter int TABLE_OCTAVES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  wto_item_t   in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output wto_result_t out_data
);

	localparam int DEPTH = SAMPLES_PER_CYCLE * (1 + 3 * TABLE_OCTAVES);
	localparam int AW = $clog2(DEPTH);

	logic                accept;
	logic                tick_accept;
	logic                busy;
	logic                room;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [SAMPLE_W-1:0] wdata;
	logic [AW-1:0]       raddr;
	logic [SAMPLE_W-1:0] rdata;
	wto_meta_t           meta_s2;
	logic                push;
	wto_result_t         result;

	assign in_ready    = !busy && room;
	assign accept      = in_valid && in_ready;
	assign tick_accept = accept && (in_data.mode == MODE_TICK);

	wto_ctrl #(
		.SAMPLES_PER_CYCLE(SAMPLES_PER_CYCLE),
		.TABLE_OCTAVES(TABLE_OCTAVES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(in_data),
		.busy(busy),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.meta_s2(meta_s2)
	);

	wto_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_wave_mem (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	wto_interp u_interp (
		.clk(clk),
		.arst_n(arst_n),
		.meta_s2(meta_s2),
		.rdata(rdata),
		.push(push),
		.result(result)
	);

	wto_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.reserve(tick_accept),
		.push(push),
		.push_data(result),
		.room(room),
		.valid(out_valid),
		.ready(out_ready),
		.data(out_data)
	);

endmodule

`default_nettype wire

// ===== tb/tb_wavetable_oscillator_top.sv =====
// Self-checking testbench for wavetable_oscillator_top: a directed table, then random beats,
// each output sample compared against a behavioural voice model in this file or a directed value.
// Depends on wto_pkg and the wavetable_oscillator_top RTL only.

module tb_wavetable_oscillator_top import wto_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPC          = 512;
	localparam int OCTS         = 8;
	localparam int WAVE_DEPTH   = SPC * (1 + 3 * OCTS);
	localparam int ITEM_BEATS   = 1900;
	localparam int QUIET_BEATS  = 250;
	localparam int SINK_HOLD    = 100;
	localparam int RUN_LIMIT_NS = 5_000_000;

	localparam logic [2:0] WF_BAD_LOW  = 3'd5;
	localparam logic [2:0] WF_BAD_HIGH = 3'd7;

	typedef struct packed {
		logic              running;
		logic [NOTE_W-1:0] note;
		logic [STEP_W-1:0] step_whole;
		logic [FRAC_W-1:0] step_frac;
		wto_wave_t         wave;
		logic              pend_note_ok;
		logic [NOTE_W-1:0] pend_note;
		logic [STEP_W-1:0] pend_step_whole;
		logic [FRAC_W-1:0] pend_step_frac;
		logic              pend_wave_ok;
		wto_wave_t         pend_wave;
		logic [9:0]        phase_whole;
		logic [FRAC_W-1:0] phase_frac;
	} voice_t;

	typedef struct packed {
		wto_item_t   beat;
		logic        typed;
		wto_result_t want;
	} drow_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	wto_item_t   in_data;
	logic        out_valid;
	logic        out_ready;
	wto_result_t out_data;

	voice_t             osc;
	logic signed [15:0] wave_words [WAVE_DEPTH];
	bit                 word_written [WAVE_DEPTH];
	wto_result_t        expected_samples [$];

	int  mismatches      = 0;
	int  samples_checked = 0;
	int  beats_sent      = 0;
	int  ticks_sent      = 0;
	int  notes_sent      = 0;
	int  waves_sent      = 0;
	int  words_sent      = 0;
	int  holds_asked     = 0;
	int  holds_taken     = 0;
	bit  quiet_tail      = 1'b0;

	// mode, note, step whole, step fraction, waveform, kind, octave, position, value
	drow_t directed [25] = '{
		'{'{MODE_TICK, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b1, '0},
		'{'{MODE_TABLE, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SAW, 3'd0, 9'd0, 16'h8000}, 1'b0, '0},
		'{'{MODE_TABLE, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SAW, 3'd0, 9'd1, 16'h7fff}, 1'b0, '0},
		'{'{MODE_TABLE, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd7, 9'd0, 16'h7fff}, 1'b0, '0},
		'{'{MODE_TABLE, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SQUARE, 3'd7, 9'd511, 16'h8000},
			1'b0, '0},
		'{'{MODE_TABLE, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_TRIANGLE, 3'd0, 9'd256, 16'h0001},
			1'b0, '0},
		'{'{MODE_NOTE, 7'd127, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0},
		'{'{MODE_NOTE, 7'd0, 9'd511, 16'hffff, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0},
		'{'{MODE_TICK, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b1, '0},
		'{'{MODE_WAVE, 7'd0, 9'd0, 16'h0000, WF_BAD_LOW, KIND_SINE, 3'd0, 9'd0, 16'h0000},
			1'b0, '0},
		'{'{MODE_WAVE, 7'd0, 9'd0, 16'h0000, WF_BAD_HIGH, KIND_SINE, 3'd0, 9'd0, 16'h0000},
			1'b0, '0},
		'{'{MODE_TICK, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b1, '0},
		'{'{MODE_WAVE, 7'd0, 9'd0, 16'h0000, WF_RSAW, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0},
		'{'{MODE_TICK, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000},
			1'b1, '{16'h8000, 1'b1}},
		'{'{MODE_NOTE, 7'd127, 9'd300, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000},
			1'b0, '0},
		'{'{MODE_WAVE, 7'd0, 9'd0, 16'h0000, WF_LSAW, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0},
		'{'{MODE_TICK, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0},
		'{'{MODE_TICK, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0},
		'{'{MODE_WAVE, 7'd0, 9'd0, 16'h0000, WF_SINE, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0},
		'{'{MODE_TICK, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0},
		'{'{MODE_WAVE, 7'd0, 9'd0, 16'h0000, WF_SQUARE, KIND_SINE, 3'd0, 9'd0, 16'h0000},
			1'b0, '0},
		'{'{MODE_NOTE, 7'd95, 9'd37, 16'h4321, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0},
		'{'{MODE_WAVE, 7'd0, 9'd0, 16'h0000, WF_TRIANGLE, KIND_SINE, 3'd0, 9'd0, 16'h0000},
			1'b0, '0},
		'{'{MODE_TICK, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0},
		'{'{MODE_TICK, 7'd0, 9'd0, 16'h0000, 3'd0, KIND_SINE, 3'd0, 9'd0, 16'h0000}, 1'b0, '0}
	};

	wavetable_oscillator_top #(
		.SAMPLES_PER_CYCLE(SPC),
		.TABLE_OCTAVES(OCTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	task automatic flag_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic void take_note(inout voice_t v);
		v.note         = v.pend_note;
		v.step_whole   = v.pend_step_whole;
		v.step_frac    = v.pend_step_frac;
		v.pend_note_ok = 1'b0;
	endfunction

	function automatic void take_wave(inout voice_t v);
		v.wave         = v.pend_wave;
		v.pend_wave_ok = 1'b0;
	endfunction

	// Advance the voice by one tick; adr_lo/adr_hi are the words read, WAVE_DEPTH if none.
	function automatic wto_result_t osc_tick(inout voice_t v, output int unsigned adr_lo,
			output int unsigned adr_hi);
		int unsigned fsum, wsum, octave, base, nxt;
		longint      lo_w, hi_w, w, mix;
		logic [15:0] r;
		wto_result_t res;
		adr_lo = WAVE_DEPTH;
		adr_hi = WAVE_DEPTH;
		res    = '0;
		if (!v.running && (!v.pend_note_ok || !v.pend_wave_ok)) begin
			return res;
		end
		if (!v.running) begin
			take_note(v);
			take_wave(v);
			v.phase_whole = '0;
			v.phase_frac  = '0;
			v.running     = 1'b1;
		end else begin
			fsum = v.phase_frac + v.step_frac;
			wsum = v.phase_whole + v.step_whole + (fsum >> 16);
			v.phase_frac = fsum[15:0];
			if (wsum >= SPC) begin
				wsum = wsum % SPC;
				if (v.pend_note_ok)
					take_note(v);
				if (v.pend_wave_ok)
					take_wave(v);
			end
			v.phase_whole = 10'(wsum);
		end
		octave = v.note / 12;
		if (octave >= OCTS || v.wave == WF_SINE) begin
			base = 0;
		end else begin
			case (v.wave)
				WF_SQUARE:   base = SPC * (1 + octave);
				WF_TRIANGLE: base = SPC * (1 + OCTS + octave);
				default:     base = SPC * (1 + 2 * OCTS + octave);
			endcase
		end
		nxt    = (v.phase_whole + 1 >= SPC) ? 0 : v.phase_whole + 1;
		adr_lo = base + v.phase_whole;
		adr_hi = base + nxt;
		lo_w   = wave_words[adr_lo];
		hi_w   = wave_words[adr_hi];
		w      = v.phase_frac;
		mix    = (lo_w * (longint'(FRAC_FULL) - w)) / longint'(FRAC_FULL)
			+ (hi_w * w) / longint'(FRAC_FULL);
		r = mix[15:0];
		if (octave < OCTS && v.wave == WF_RSAW)
			r = ~r + 16'd1;
		res.sample_out = r;
		res.playing    = 1'b1;
		return res;
	endfunction

	function automatic wto_item_t noise_beat(wto_mode_t m);
		wto_item_t it;
		it.mode           = m;
		it.note_number    = 7'($urandom);
		it.step_whole     = 9'($urandom);
		it.step_fraction  = 16'($urandom);
		it.waveform_code  = 3'($urandom);
		it.table_kind     = wto_kind_t'(2'($urandom));
		it.table_octave   = 3'($urandom);
		it.table_position = 9'($urandom);
		it.table_value    = 16'($urandom);
		return it;
	endfunction

	task automatic send_beat(wto_item_t it, logic typed = 1'b0, wto_result_t want = '0);
		int          slot;
		int unsigned lo, hi;
		wto_result_t got;
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		case (it.mode)
			MODE_NOTE: begin
				osc.pend_note       = it.note_number;
				osc.pend_step_whole = it.step_whole;
				osc.pend_step_frac  = it.step_fraction;
				osc.pend_note_ok    = 1'b1;
				notes_sent++;
			end
			MODE_WAVE: begin
				if (it.waveform_code <= WF_LSAW) begin
					osc.pend_wave    = wto_wave_t'(it.waveform_code);
					osc.pend_wave_ok = 1'b1;
				end
				waves_sent++;
			end
			MODE_TABLE: begin
				if (it.table_kind == KIND_SINE)
					slot = 0;
				else if (it.table_octave < OCTS)
					slot = 1 + (int'(it.table_kind) - 1) * OCTS + it.table_octave;
				else
					slot = -1;
				if (slot >= 0 && it.table_position < SPC) begin
					wave_words[slot * SPC + it.table_position]   = it.table_value;
					word_written[slot * SPC + it.table_position] = 1'b1;
				end
				words_sent++;
			end
			default: begin
				got = osc_tick(osc, lo, hi);
				expected_samples.push_back(typed ? want : got);
				ticks_sent++;
			end
		endcase
	endtask

	// Write any word the next tick would read that has never been loaded.
	task automatic prime_reads();
		voice_t      peek;
		wto_result_t unused;
		int unsigned lo, hi, adr, slot;
		wto_item_t   it;
		peek   = osc;
		unused = osc_tick(peek, lo, hi);
		for (int k = 0; k < 2; k++) begin
			adr = k ? hi : lo;
			if (adr < WAVE_DEPTH && !word_written[adr]) begin
				it = noise_beat(MODE_TABLE);
				slot = adr / SPC;
				it.table_position = 9'(adr % SPC);
				if (slot == 0) begin
					it.table_kind = KIND_SINE;
				end else begin
					it.table_kind   = wto_kind_t'(2'(1 + (slot - 1) / OCTS));
					it.table_octave = 3'((slot - 1) % OCTS);
				end
				send_beat(it);
			end
		end
	endtask

	initial begin : stimulus
		wto_item_t it;
		int        pick;
		osc      = '0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].beat.mode == MODE_TICK)
				prime_reads();
			send_beat(directed[i].beat, directed[i].typed, directed[i].want);
		end

		for (int n = 0; beats_sent < ITEM_BEATS; n++) begin
			quiet_tail = (beats_sent >= ITEM_BEATS - QUIET_BEATS);
			if (n == 250) begin
				// hold the sink and keep ticking so the result queue fills
				holds_asked++;
				repeat (24) begin
					prime_reads();
					send_beat(noise_beat(MODE_TICK));
				end
			end
			if (n == 500) begin
				in_valid <= 1'b0;
				while (expected_samples.size() != 0) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				prime_reads();
				send_beat(noise_beat(MODE_TICK));
			end else if (pick < 60) begin
				it = noise_beat(MODE_NOTE);
				it.step_whole = ($urandom_range(0, 6) == 0) ? 9'($urandom_range(4, 31))
					: 9'($urandom_range(32, 511));
				send_beat(it);
			end else if (pick < 75) begin
				send_beat(noise_beat(MODE_WAVE));
			end else begin
				send_beat(noise_beat(MODE_TABLE));
			end
		end

		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		$display("Run covered %0d ticks, %0d note and %0d waveform requests, %0d table words.",
			ticks_sent, notes_sent, waves_sent, words_sent);
		$display("%0d samples compared, %0d mismatches.", samples_checked, mismatches);
		if (mismatches == 0) begin
			$display("wavetable_oscillator_top verification clean");
		end else begin
			$display("wavetable_oscillator_top verification failed");
		end
		$finish;
	end

	initial begin : sink_pacing
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_taken != holds_asked) begin
				holds_taken++;
				out_ready <= 1'b0;
				repeat (SINK_HOLD) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : sample_check
		wto_result_t want;
		if (out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat: sample %0d playing %0b",
					out_data.sample_out, out_data.playing));
			end else begin
				want = expected_samples.pop_front();
				samples_checked++;
				if (out_data.sample_out !== want.sample_out)
					flag_mismatch($sformatf("sample %0d, expected %0d",
						out_data.sample_out, want.sample_out));
				if (out_data.playing !== want.playing)
					flag_mismatch($sformatf("playing %0b, expected %0b",
						out_data.playing, want.playing));
			end
		end
	end

	initial begin : watchdog
		#RUN_LIMIT_NS;
		$display("Timed out with %0d samples outstanding.", expected_samples.size());
		$display("wavetable_oscillator_top verification failed");
		$finish;
	end

endmodule
